>>> rtl/lzss_frame_decompressor_defines.svh
// Assertion macros for the checker file of the LZSS frame decompressor.
`ifndef LZSS_FRAME_DECOMPRESSOR_DEFINES_SVH
`define LZSS_FRAME_DECOMPRESSOR_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define LZFD_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lzfd assertion failed");

// Next-cycle implication, sampled on clock, off while reset is high.
`define LZFD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lzfd assertion failed");

`endif

>>> rtl/lzfd_pkg.sv
// Shared types and constants of the LZSS frame decompressor.
`timescale 1ns / 1ps
`default_nettype none
package lzfd_pkg;

   localparam int HISTORY_DEPTH_DEF = 2048;
   localparam int DIST_W            = 11;
   localparam int LEN_W             = 6;
   localparam int QUEUE_DEPTH       = 4;
   localparam int CSR_ADDR_W        = 3;

   localparam logic [LEN_W-1:0] LEN_BIAS          = 6'd3;
   localparam logic [15:0]      FRAME_SIZE_RESET  = 16'd23040;
   localparam logic [7:0]       FRAME_TOTAL_RESET = 8'd16;
   localparam logic [3:0]       FLAG_COUNT        = 4'd8;

   // register index, taken from paddr[2]
   typedef enum logic {
      CSR_FRAME_SIZE  = 1'b0,
      CSR_FRAME_TOTAL = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [15:0] frame_size;
      logic [7:0]  frame_total;
      logic        size_wr;
   } cfg_type;

   // one decoded item: a literal or a match
   typedef struct packed {
      logic              is_match;
      logic [7:0]        lit;
      logic [LEN_W-1:0]  len;
      logic [DIST_W-1:0] back;
      logic              frame_end;
      logic              all_done;
   } cmd_type;

   typedef struct packed {
      logic [7:0] data;
      logic       run_last;
      logic       frame_end;
      logic       all_done;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/lzss_frame_decompressor.sv
// Top level of the LZSS frame decompressor: register port, front end, queue, back end.
`timescale 1ns / 1ps
`default_nettype none
// LZSS decoder with a HISTORY_DEPTH-byte history ring. The front end takes one
// compressed byte per cycle while its four-entry command queue has room: flag
// bytes and token low bytes are absorbed, literals and token high bytes become
// commands. The back end emits one decompressed byte per cycle, while its output
// buffer has room, through the single read port of the history RAM: a literal
// is one beat, a match first computes its source address and then reads the
// ring once per byte, so input stalls while matches drain the queue.
// Output beats pass through a two-entry buffer, so a stalled consumer does not
// stop the front end until the queue fills. History is not cleared at reset;
// matches must only reach bytes already written. The user must write frame_size
// (0x0) and frame_total (0x4) only while the block is idle; the block does not check this.
module lzss_frame_decompressor import lzfd_pkg::*; #(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // compressed byte input
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_in_byte,
   // decompressed byte output
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [7:0]            rsp_out_byte,
   output logic                       rsp_run_last,
   output logic                       rsp_frame_end,
   output logic                       rsp_all_done,
   // register port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic      [31:0]           prdata,
   output logic                       pready
);

   logic [15:0]   frame_size_ff;
   logic [7:0]    frame_total_ff;
   logic          csr_wr;
   csr_index_type csr_idx;
   cfg_type       cfg;

   logic          q_push, q_full, q_pop, q_valid;
   cmd_type       push_cmd, head_cmd;
   rsp_type       rsp;

   assign pready  = 1'b1;
   assign csr_idx = csr_index_type'(paddr[2]);
   assign csr_wr  = psel & penable & pwrite;

   // register read
   always_comb begin
      case (csr_idx)
         CSR_FRAME_SIZE:  prdata = {16'd0, frame_size_ff};
         CSR_FRAME_TOTAL: prdata = {24'd0, frame_total_ff};
         default:         prdata = 32'd0;
      endcase
   end

   // register write
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_size_ff  <= FRAME_SIZE_RESET;
         frame_total_ff <= FRAME_TOTAL_RESET;
      end else if (csr_wr) begin
         if (csr_idx == CSR_FRAME_SIZE) begin
            frame_size_ff <= pwdata[15:0];
         end else begin
            frame_total_ff <= pwdata[7:0];
         end
      end
   end

   always_comb begin
      cfg.frame_size  = frame_size_ff;
      cfg.frame_total = frame_total_ff;
      cfg.size_wr     = csr_wr && (csr_idx == CSR_FRAME_SIZE);
   end

   // frame_size write reloads the count with the new value
   logic [15:0] size_now;
   assign size_now = cfg.size_wr ? pwdata[15:0] : frame_size_ff;

   cfg_type front_cfg;
   always_comb begin
      front_cfg            = cfg;
      front_cfg.frame_size = size_now;
   end

   lzfd_front #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (front_cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (push_cmd)
   );

   lzfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (head_cmd)
   );

   lzfd_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (head_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_out_byte  = rsp.data;
   assign rsp_run_last  = rsp.run_last;
   assign rsp_frame_end = rsp.frame_end;
   assign rsp_all_done  = rsp.all_done;

endmodule
`default_nettype wire

>>> rtl/lzfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lzfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read returns the old content on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

>>> rtl/lzfd_front.sv
// Front end: parses flag bytes and tokens, keeps frame accounting, issues item commands.
`timescale 1ns / 1ps
`default_nettype none
module lzfd_front import lzfd_pkg::*; #(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       q_full,
   output logic            q_push,
   output cmd_type         q_cmd
);

   localparam int MOD_STEPS = (2 ** DIST_W) / HISTORY_DEPTH;
   localparam logic [DIST_W:0] DEPTH_V = (DIST_W + 1)'(HISTORY_DEPTH);

   typedef enum logic [1:0] {
      PH_FLAG = 2'd0,
      PH_ITEM = 2'd1,
      PH_HIGH = 2'd2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  flag_bits_ff, flag_bits_in;
   logic [3:0]  flag_index_ff, flag_index_in;
   logic [7:0]  token_low_ff, token_low_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  frames_done_ff, frames_done_in;

   logic             accept;
   logic             done;
   logic             flag_bit;
   logic             item_done;
   logic [LEN_W-1:0] item_len;
   logic [15:0]      left_dec;
   logic             frame_hit;
   logic [7:0]       frames_inc;
   logic [3:0]       index_inc;
   logic [DIST_W:0]  back_mod;

   assign req_ready = ~q_full;
   assign accept    = req_valid & ~q_full;
   assign done      = (frames_done_ff >= cfg.frame_total);
   assign flag_bit  = flag_bits_ff[flag_index_ff[2:0]];

   // item length: one for a literal, token length for a match
   assign item_len  = (phase_ff == PH_HIGH) ? ({1'b0, req_in_byte[7:3]} + LEN_BIAS)
                                            : LEN_W'(1);
   assign left_dec  = (bytes_left_ff > {10'b0, item_len}) ?
                      (bytes_left_ff - {10'b0, item_len}) : 16'd0;
   assign frame_hit = (left_dec == 16'd0);
   assign frames_inc = frames_done_ff + 8'd1;
   assign index_inc  = flag_index_ff + 4'd1;

   // distance plus one, reduced modulo the ring depth
   always_comb begin
      back_mod = {1'b0, req_in_byte[2:0], token_low_ff} + (DIST_W + 1)'(1);
      for (int i = 0; i < MOD_STEPS; i++) begin
         if (back_mod >= DEPTH_V) begin
            back_mod = back_mod - DEPTH_V;
         end
      end
   end

   // next state
   always_comb begin
      phase_in       = phase_ff;
      flag_bits_in   = flag_bits_ff;
      flag_index_in  = flag_index_ff;
      token_low_in   = token_low_ff;
      bytes_left_in  = bytes_left_ff;
      frames_done_in = frames_done_ff;
      item_done      = 1'b0;

      if (accept && !done) begin
         case (phase_ff)
            PH_ITEM: begin
               if (flag_bit) begin
                  token_low_in = req_in_byte;
                  phase_in     = PH_HIGH;
               end else begin
                  item_done = 1'b1;
               end
            end
            PH_HIGH: begin
               item_done = 1'b1;
            end
            default: begin
               flag_bits_in  = req_in_byte;
               flag_index_in = 4'd0;
               phase_in      = PH_ITEM;
            end
         endcase
      end

      if (item_done) begin
         flag_index_in = index_inc;
         if (frame_hit) begin
            bytes_left_in  = cfg.frame_size;
            frames_done_in = frames_inc;
            flag_index_in  = FLAG_COUNT;
            phase_in       = PH_FLAG;
         end else begin
            bytes_left_in = left_dec;
            phase_in      = (index_inc >= FLAG_COUNT) ? PH_FLAG : PH_ITEM;
         end
      end

      // frame size write reloads the byte count
      if (cfg.size_wr) begin
         bytes_left_in = cfg.frame_size;
      end
   end

   // command to the back end
   always_comb begin
      q_push          = item_done;
      q_cmd.is_match  = (phase_ff == PH_HIGH);
      q_cmd.lit       = req_in_byte;
      q_cmd.len       = item_len;
      q_cmd.back      = back_mod[DIST_W-1:0];
      q_cmd.frame_end = frame_hit;
      q_cmd.all_done  = frame_hit && (frames_inc >= cfg.frame_total);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_FLAG;
         flag_bits_ff   <= 8'd0;
         flag_index_ff  <= FLAG_COUNT;
         token_low_ff   <= 8'd0;
         bytes_left_ff  <= FRAME_SIZE_RESET;
         frames_done_ff <= 8'd0;
      end else begin
         phase_ff       <= phase_in;
         flag_bits_ff   <= flag_bits_in;
         flag_index_ff  <= flag_index_in;
         token_low_ff   <= token_low_in;
         bytes_left_ff  <= bytes_left_in;
         frames_done_ff <= frames_done_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/lzfd_queue.sv
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module lzfd_queue import lzfd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         head_valid,
   output cmd_type      head_cmd
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/lzfd_back.sv
// Back end: runs literals and matches against the history ring, buffers output beats.
`timescale 1ns / 1ps
`default_nettype none
module lzfd_back import lzfd_pkg::*; #(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_valid,
   input  wire cmd_type q_cmd,
   output logic         q_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam logic [AW:0]   DEPTH_V   = (AW + 1)'(HISTORY_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
      return (p == LAST_ADDR) ? '0 : p + 1'b1;
   endfunction

   // match sequencer
   logic             act_ff;
   logic [LEN_W-1:0] rem_ff;
   logic [AW-1:0]    src_ff;
   logic [AW-1:0]    wp_ff;
   logic             fe_ff, ad_ff;

   // ring read / write stage
   logic             s2_valid_ff;
   logic             s2_rd_ff;
   rsp_type          s2_ff;
   logic [AW-1:0]    s2_addr_ff;
   logic             fwd_hit_ff;
   logic [7:0]       fwd_data_ff;
   logic [7:0]       ram_q;
   logic [7:0]       s2_data;

   // output buffer, two entries
   rsp_type          ob_ff [2];
   logic             ob_wr_ff, ob_rd_ff;
   logic [1:0]       ob_cnt_ff;

   logic             pop_out;
   logic             room;
   logic             issue, issue_rd, load;
   rsp_type          issue_info;
   logic [AW:0]      src_sum;
   logic [AW-1:0]    src_start;

   assign rsp_valid = (ob_cnt_ff != 2'd0);
   assign rsp       = ob_ff[ob_rd_ff];
   assign pop_out   = rsp_valid & rsp_ready;

   // a beat may enter only if it has a buffer slot when it lands
   assign room = ({1'b0, ob_cnt_ff} + {2'b0, s2_valid_ff}) < (3'd2 + {2'b0, pop_out});

   assign s2_data = s2_rd_ff ? (fwd_hit_ff ? fwd_data_ff : ram_q) : s2_ff.data;

   // match source: write position minus distance, modulo ring depth
   always_comb begin
      src_sum = {1'b0, wp_ff} + DEPTH_V - {1'b0, q_cmd.back[AW-1:0]};
      if (src_sum >= DEPTH_V) begin
         src_sum = src_sum - DEPTH_V;
      end
      src_start = src_sum[AW-1:0];
   end

   // issue control
   always_comb begin
      issue      = 1'b0;
      issue_rd   = 1'b0;
      load       = 1'b0;
      q_pop      = 1'b0;
      issue_info = '{data: q_cmd.lit, run_last: 1'b1,
                     frame_end: q_cmd.frame_end, all_done: q_cmd.all_done};
      if (act_ff) begin
         if (room) begin
            issue    = 1'b1;
            issue_rd = 1'b1;
            issue_info.run_last  = (rem_ff == LEN_W'(1));
            issue_info.frame_end = fe_ff && (rem_ff == LEN_W'(1));
            issue_info.all_done  = ad_ff && (rem_ff == LEN_W'(1));
         end
      end else if (q_valid) begin
         if (q_cmd.is_match) begin
            load  = 1'b1;
            q_pop = 1'b1;
         end else if (room) begin
            issue = 1'b1;
            q_pop = 1'b1;
         end
      end
   end

   lzfd_ram #(
      .WIDTH (8),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (s2_valid_ff),
      .wr_addr (s2_addr_ff),
      .wr_data (s2_data),
      .rd_addr (src_ff),
      .rd_data (ram_q)
   );

   // payload registers
   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff <= q_cmd.len;
         src_ff <= src_start;
         fe_ff  <= q_cmd.frame_end;
         ad_ff  <= q_cmd.all_done;
      end else if (issue_rd) begin
         rem_ff <= rem_ff - 1'b1;
         src_ff <= wrap_inc(src_ff);
      end
      if (issue) begin
         s2_rd_ff   <= issue_rd;
         s2_ff      <= issue_info;
         s2_addr_ff <= wp_ff;
      end
      // same-address read and write: take the byte being written
      fwd_data_ff <= s2_data;
      if (s2_valid_ff) begin
         ob_ff[ob_wr_ff] <= '{data: s2_data, run_last: s2_ff.run_last,
                              frame_end: s2_ff.frame_end, all_done: s2_ff.all_done};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff      <= 1'b0;
         wp_ff       <= '0;
         s2_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
         ob_wr_ff    <= 1'b0;
         ob_rd_ff    <= 1'b0;
         ob_cnt_ff   <= 2'd0;
      end else begin
         if (load) begin
            act_ff <= 1'b1;
         end else if (issue_rd && (rem_ff == LEN_W'(1))) begin
            act_ff <= 1'b0;
         end
         if (issue) begin
            wp_ff <= wrap_inc(wp_ff);
         end
         s2_valid_ff <= issue;
         fwd_hit_ff  <= issue_rd && s2_valid_ff && (src_ff == s2_addr_ff);
         if (s2_valid_ff) begin
            ob_wr_ff <= ~ob_wr_ff;
         end
         if (pop_out) begin
            ob_rd_ff <= ~ob_rd_ff;
         end
         ob_cnt_ff <= ob_cnt_ff + {1'b0, s2_valid_ff} - {1'b0, pop_out};
      end
   end

endmodule
`default_nettype wire

>>> rtl/lzfd_checker.sv
// Port-level checker for the LZSS frame decompressor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "lzss_frame_decompressor_defines.svh"
module lzfd_checker import lzfd_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [7:0]            rsp_out_byte,
   input wire logic                  rsp_run_last,
   input wire logic                  rsp_frame_end,
   input wire logic                  rsp_all_done,
   input wire logic                  psel,
   input wire logic                  penable,
   input wire logic                  pwrite,
   input wire logic [CSR_ADDR_W-1:0] paddr,
   input wire logic [31:0]           pwdata,
   input wire logic [31:0]           prdata
);

   logic [10:0] rsp_beat;
   logic        csr_total_wr;

   assign rsp_beat     = {rsp_out_byte, rsp_run_last, rsp_frame_end, rsp_all_done};
   assign csr_total_wr = psel & penable & pwrite & paddr[2];

   // a stalled output beat keeps its contents
   `LZFD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_beat))

   // a frame only ends on the last beat of an item
   `LZFD_ASSERT_NOW(a_frame_end_last, rsp_valid && rsp_frame_end, rsp_run_last)

   // the final frame is also a frame end
   `LZFD_ASSERT_NOW(a_all_done_frame, rsp_valid && rsp_all_done, rsp_frame_end)

   // a written frame_total reads back on the next cycle
   `LZFD_ASSERT_NEXT(a_total_readback, csr_total_wr, !paddr[2] || (prdata[7:0] == $past(pwdata[7:0])))

endmodule

bind lzss_frame_decompressor lzfd_checker u_checker (.*);
`default_nettype wire

>>> dv/tb_lzss_frame_decompressor.sv
// Self-checking testbench for the LZSS frame decompressor: stream driver, decode predictor, beat checker.
`timescale 1ns / 1ps
module tb_lzss_frame_decompressor;
   import lzfd_pkg::*;

   localparam int HIST_D = HISTORY_DEPTH_DEF;

   typedef enum logic [1:0] {
      DEC_FLAG     = 2'd0,
      DEC_ITEM     = 2'd1,
      DEC_TOKEN_HI = 2'd2
   } dec_state_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_in_byte = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   logic [7:0]            rsp_out_byte;
   logic                  rsp_run_last;
   logic                  rsp_frame_end;
   logic                  rsp_all_done;
   logic                  psel        = 1'b0;
   logic                  penable     = 1'b0;
   logic                  pwrite      = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr       = '0;
   logic [31:0]           pwdata      = 32'h0;
   logic [31:0]           prdata;
   logic                  pready;

   lzss_frame_decompressor uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_byte   (req_in_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_frame_end (rsp_frame_end),
      .rsp_all_done  (rsp_all_done),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   always #5 clock = ~clock;

   // compressed bytes waiting to be driven, decoded beats waiting to arrive
   logic [7:0] in_byte_q[$];
   rsp_type    out_beat_q[$];
   int         mismatches = 0;
   bit         beat_taken = 1'b0;
   bit         calm       = 1'b0;

   // decoder shadow state
   logic [7:0]        hist_mem [0:HIST_D-1];
   logic [DIST_W-1:0] hist_wp     = '0;
   logic [7:0]        flag_byte   = 8'h00;
   logic [3:0]        flag_pos    = FLAG_COUNT;
   dec_state_type     dec_state   = DEC_FLAG;
   logic [7:0]        tok_low     = 8'h00;
   logic [15:0]       bytes_left  = FRAME_SIZE_RESET;
   logic [7:0]        frames_done = 8'h00;
   logic [15:0]       cfg_size    = FRAME_SIZE_RESET;
   logic [7:0]        cfg_total   = FRAME_TOTAL_RESET;

   // stream generator bookkeeping
   int g_written  = 0;
   int g_left     = FRAME_SIZE_RESET;
   int g_fsize    = FRAME_SIZE_RESET;
   int g_ftotal   = FRAME_TOTAL_RESET;
   int g_frames   = 0;
   int g_items    = 0;
   bit g_over     = 1'b0;
   bit g_far_done = 1'b0;

   task automatic note_error(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR: %s", msg);
   endtask

   // Decode one accepted compressed byte and queue the beats it produces.
   task automatic decode_byte(input logic [7:0] b);
      logic [7:0]        vals [0:33];
      logic [15:0]       token;
      logic [DIST_W-1:0] src;
      logic              end_f;
      logic              done_f;
      rsp_type           beat;
      int                n;
      int                k;
      n = 0;
      end_f = 1'b0;
      done_f = 1'b0;
      if (frames_done >= cfg_total) return;
      case (dec_state)
         DEC_ITEM: begin
            if (!flag_byte[flag_pos[2:0]]) begin
               hist_mem[hist_wp] = b;
               hist_wp++;
               vals[0] = b;
               n = 1;
            end else begin
               tok_low = b;
               dec_state = DEC_TOKEN_HI;
            end
         end
         DEC_TOKEN_HI: begin
            token = {b, tok_low};
            n = int'(token[15:11]) + 3;
            // back of zero (distance field all ones) reads the oldest entry
            src = hist_wp - (token[DIST_W-1:0] + 1'b1);
            for (k = 0; k < n; k++) begin
               vals[k] = hist_mem[src];
               hist_mem[hist_wp] = vals[k];
               hist_wp++;
               src++;
            end
         end
         default: begin
            flag_byte = b;
            flag_pos = 4'd0;
            dec_state = DEC_ITEM;
         end
      endcase
      if (n == 0) return;
      // frame accounting; an overrunning match saturates at zero
      bytes_left = (bytes_left > n) ? bytes_left - 16'(n) : 16'd0;
      flag_pos++;
      if (bytes_left == 16'd0) begin
         end_f = 1'b1;
         frames_done++;
         done_f = (frames_done >= cfg_total);
         bytes_left = cfg_size;
         flag_pos = FLAG_COUNT;
         dec_state = DEC_FLAG;
      end else if (flag_pos >= FLAG_COUNT) begin
         dec_state = DEC_FLAG;
      end else begin
         dec_state = DEC_ITEM;
      end
      for (k = 0; k < n; k++) begin
         beat.data      = vals[k];
         beat.run_last  = (k == n - 1);
         beat.frame_end = end_f && (k == n - 1);
         beat.all_done  = done_f && (k == n - 1);
         out_beat_q.push_back(beat);
      end
   endtask

   // Input driver: accept at rising edge, present next beat at falling edge.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         decode_byte(req_in_byte);
         beat_taken = 1'b1;
      end
   end

   always @(negedge clock) begin : drive_in
      logic       nv;
      logic [7:0] nb;
      nv = req_valid;
      nb = req_in_byte;
      if (reset) begin
         nv = 1'b0;
      end else if (!req_valid || beat_taken) begin
         if (in_byte_q.size() > 0 && (calm || $urandom_range(0, 99) >= 13)) begin
            nv = 1'b1;
            nb = in_byte_q.pop_front();
         end else begin
            nv = 1'b0;
         end
      end
      beat_taken = 1'b0;
      req_valid   <= nv;
      req_in_byte <= nb;
      rsp_ready   <= !reset && (calm || $urandom_range(0, 99) >= 13);
   end

   // Output checker: each beat against the oldest expectation.
   always @(posedge clock) begin : check_out
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.data      = rsp_out_byte;
         got.run_last  = rsp_run_last;
         got.frame_end = rsp_frame_end;
         got.all_done  = rsp_all_done;
         if (out_beat_q.size() == 0) begin
            note_error($sformatf("unexpected beat byte %h last %b end %b done %b",
               got.data, got.run_last, got.frame_end, got.all_done));
         end else begin
            want = out_beat_q.pop_front();
            if (got !== want)
               note_error($sformatf(
                  "beat exp byte %h last %b end %b done %b, got %h %b %b %b",
                  want.data, want.run_last, want.frame_end, want.all_done,
                  got.data, got.run_last, got.frame_end, got.all_done));
         end
      end
   end

   // One register transfer; a read is checked against the shadow copy.
   task automatic csr_access(input csr_index_type idx, input logic wr, input logic [31:0] val);
      logic [31:0] want;
      logic [31:0] mask;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= wr ? val : 32'h0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (!wr) begin
         want = (idx == CSR_FRAME_SIZE) ? {16'h0, cfg_size} : {24'h0, cfg_total};
         mask = (idx == CSR_FRAME_SIZE) ? 32'h0000_FFFF : 32'h0000_00FF;
         if ((prdata & mask) !== want)
            note_error($sformatf("register %0d read exp %h, got %h", idx, want, prdata));
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_reg(input csr_index_type idx, input int v);
      csr_access(idx, 1'b1, 32'(v));
      if (idx == CSR_FRAME_SIZE) begin
         cfg_size = 16'(v);
         bytes_left = 16'(v);
         g_fsize = v;
         g_left = v;
      end else begin
         cfg_total = 8'(v);
         g_ftotal = v;
      end
      csr_access(idx, 1'b0, 32'h0);
   endtask

   // Track what the stream does to frame progress as it is built.
   task automatic account(input int n);
      g_written += n;
      if (g_frames < g_ftotal) begin
         g_left = (g_left > n) ? g_left - n : 0;
         if (g_left == 0) begin
            g_frames++;
            g_left = g_fsize;
            g_over = 1'b1;
         end
      end
   endtask

   task automatic push_flag(input logic [7:0] f);
      in_byte_q.push_back(f);
      g_items++;
   endtask

   task automatic push_literal(input logic [7:0] b);
      in_byte_q.push_back(b);
      g_items++;
      account(1);
   endtask

   task automatic push_token(input int code, input int reach);
      logic [15:0] tok;
      tok = {code[4:0], reach[10:0]};
      in_byte_q.push_back(tok[7:0]);
      in_byte_q.push_back(tok[15:8]);
      g_items += 2;
      account(code + 3);
   endtask

   // One flag byte and its items; stops at a frame end, later flag bits stay random.
   task automatic gen_group(input int tok_pct, input int long_pct);
      logic [7:0] fl;
      int         slot;
      int         i;
      int         lim;
      int         code;
      int         reach;
      fl = 8'($urandom);
      slot = in_byte_q.size();
      push_flag(8'h00);
      g_over = 1'b0;
      for (i = 0; i < 8 && !g_over; i++) begin
         if (g_written > 0 && $urandom_range(0, 99) < tok_pct) begin
            fl[i] = 1'b1;
            code = ($urandom_range(0, 99) < long_pct) ? 31 : $urandom_range(0, 31);
            lim = (g_written < HIST_D) ? g_written : HIST_D;
            // only reach back as far as bytes already written
            if (lim == HIST_D && $urandom_range(0, 99) < 15) begin
               reach = HIST_D - 1;
               g_far_done = 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
               reach = 0;
            end else begin
               reach = $urandom_range(0, lim - 1);
            end
            push_token(code, reach);
         end else begin
            fl[i] = 1'b0;
            push_literal(8'($urandom));
         end
      end
      in_byte_q[slot] = fl;
   endtask

   // Wait until every byte is taken and every beat seen, then let the block settle.
   task automatic wait_idle(input int settle);
      do @(posedge clock);
      while (in_byte_q.size() != 0 || req_valid || out_beat_q.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   initial begin
      int phase_no;
      int k;
      int ng;
      int sz;
      int tot;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      csr_access(CSR_FRAME_SIZE, 1'b0, 32'h0);
      csr_access(CSR_FRAME_TOTAL, 1'b0, 32'h0);

      // reset settings: one group of edge-value literals
      push_flag(8'h00);
      push_literal(8'h00);
      push_literal(8'hFF);
      push_literal(8'h55);
      push_literal(8'hAA);
      push_literal(8'h01);
      push_literal(8'h80);
      push_literal(8'h7F);
      push_literal(8'hFE);
      wait_idle(60);

      // zero frame total: everything is ignored
      set_reg(CSR_FRAME_TOTAL, 0);
      repeat (3) in_byte_q.push_back(8'($urandom));
      wait_idle(60);

      // zero frame size: every item closes a frame
      set_reg(CSR_FRAME_TOTAL, 255);
      set_reg(CSR_FRAME_SIZE, 0);
      push_flag(8'hFE);
      push_literal(8'($urandom));
      push_flag(8'h01);
      push_token(0, 0);
      push_flag(8'hFF);
      push_token(31, 7);
      wait_idle(60);

      // match that runs past the end of a short frame
      set_reg(CSR_FRAME_SIZE, 5);
      push_flag(8'h02);
      push_literal(8'($urandom));
      push_token(31, 0);
      wait_idle(60);

      set_reg(CSR_FRAME_SIZE, 65535);
      gen_group(50, 50);

      // random phases of whole groups under changing settings
      phase_no = 0;
      while ((g_items < 230 || !g_far_done) && phase_no < 40) begin
         wait_idle(60);
         calm = (phase_no == 2 || phase_no == 3);
         case ($urandom_range(0, 9))
            0:       sz = 1;
            1:       sz = 65535;
            default: sz = $urandom_range(2, 120);
         endcase
         set_reg(CSR_FRAME_SIZE, sz);
         tot = g_frames + $urandom_range(1, 3);
         if (tot > 255 || $urandom_range(0, 7) == 0) tot = 255;
         set_reg(CSR_FRAME_TOTAL, tot);
         ng = $urandom_range(2, 6);
         for (k = 0; k < ng && g_frames < g_ftotal; k++) gen_group(60, 40);
         if (g_frames >= g_ftotal) begin
            // past the last frame: noise that must be dropped
            repeat ($urandom_range(1, 4)) in_byte_q.push_back(8'($urandom));
         end else if ($urandom_range(0, 4) == 0) begin
            // lower the total to frames already done: block stops mid-stream
            wait_idle(60);
            set_reg(CSR_FRAME_TOTAL, g_frames);
            repeat ($urandom_range(1, 4)) in_byte_q.push_back(8'($urandom));
         end
         phase_no++;
      end
      calm = 1'b0;

      wait_idle(100);
      if (out_beat_q.size() != 0) begin
         mismatches += out_beat_q.size();
         $display("ERROR: %0d expected beats never arrived", out_beat_q.size());
      end
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/lzfd_pkg.sv
rtl/lzfd_ram.sv
rtl/lzfd_front.sv
rtl/lzfd_queue.sv
rtl/lzfd_back.sv
rtl/lzss_frame_decompressor.sv
rtl/lzfd_checker.sv
dv/tb_lzss_frame_decompressor.sv
